/* rtl/core/bfa_pkg.sv */
package bfa_pkg;

    // Table geometry
    localparam int NUM_BLOCKS = 16;
    localparam int SIZE_BITS  = 16;

    // Index into the table, and a count that can also hold NUM_BLOCKS itself
    localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

    // Field widths fixed by the interface
    localparam int BIDX_W   = 4;
    localparam int SIZE_W   = 16;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    // Command codes
    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_REQUEST = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STS_LOADED    = 2'd0;
    localparam logic [STATUS_W-1:0] STS_ALLOC     = 2'd1;
    localparam logic [STATUS_W-1:0] STS_NO_ALLOC  = 2'd2;
    localparam logic [STATUS_W-1:0] STS_BAD_INDEX = 2'd3;

    // Controller to datapath
    typedef struct packed {
        logic take_item;   // input channel ready
        logic scan_step;   // issue one table read, advance the scan index
        logic finish;      // write back and load the result register
    } ctl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic req_valid;   // an item is offered
        logic req_load;    // offered item is a load
        logic count_zero;  // no blocks take part in a search
        logic scan_last;   // current scan read is the last one
        logic out_free;    // result register can take a new result
    } ctl_sts_t;

endpackage

/* rtl/core/bfa_if.sv */
// Request channel
interface bfa_req_if;
    logic                         valid;
    logic                         ready;
    logic                         command;
    logic [bfa_pkg::BIDX_W-1:0]   block_index;
    logic [bfa_pkg::SIZE_W-1:0]   size;

    modport source (output valid, output command, output block_index, output size,
                    input ready);
    modport sink   (input valid, input command, input block_index, input size,
                    output ready);
endinterface

// Result channel
interface bfa_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [bfa_pkg::STATUS_W-1:0] status;
    logic [bfa_pkg::BIDX_W-1:0]   chosen_block;
    logic [bfa_pkg::SIZE_W-1:0]   remaining;

    modport source (output valid, output status, output chosen_block, output remaining,
                    input ready);
    modport sink   (input valid, input status, input chosen_block, input remaining,
                    output ready);
endinterface

// Configuration write channel
interface bfa_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [bfa_pkg::COUNT_W-1:0]  block_count;

    modport source (output valid, output block_count, input ready);
    modport sink   (input valid, input block_count, output ready);
endinterface

/* rtl/core/bfa_ram.sv */
module bfa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/bfa_ctrl.sv */
module bfa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  bfa_pkg::ctl_sts_t sts,
    output bfa_pkg::ctl_cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_FIN   = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands
    always_comb
    begin
        state_next    = state_reg;
        cmd.take_item = 1'b0;
        cmd.scan_step = 1'b0;
        cmd.finish    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.take_item = 1'b1;
                if (sts.req_valid)
                begin
                    if (sts.req_load || sts.count_zero)
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            // last read data is compared here
            ST_DRAIN:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/core/bfa_dpath.sv */
module bfa_dpath (
    input  logic              clk,
    input  logic              rst_n,
    bfa_req_if.sink           req,
    bfa_rsp_if.source         rsp,
    bfa_cfg_if.sink           cfg,
    input  bfa_pkg::ctl_cmd_t cmd,
    output bfa_pkg::ctl_sts_t sts
);

    localparam int IDX_W     = bfa_pkg::IDX_W;
    localparam int CNT_W     = bfa_pkg::CNT_W;
    localparam int SIZE_BITS = bfa_pkg::SIZE_BITS;

    // Configuration and captured item
    logic [bfa_pkg::COUNT_W-1:0] block_count_reg;
    logic                        command_reg;
    logic [bfa_pkg::BIDX_W-1:0]  bidx_reg;
    logic [bfa_pkg::SIZE_W-1:0]  size_reg;
    logic [CNT_W-1:0]            count_reg;

    // Scan state
    logic [CNT_W-1:0]            scan_idx_reg;
    logic                        rd_pend_reg;
    logic [IDX_W-1:0]            rd_idx_reg;
    logic                        found_reg;
    logic [IDX_W-1:0]            best_reg;
    logic [SIZE_BITS-1:0]        best_left_reg;

    // Result register
    logic                        out_valid_reg;
    logic [bfa_pkg::STATUS_W-1:0] status_reg;
    logic [bfa_pkg::BIDX_W-1:0]  chosen_reg;
    logic [bfa_pkg::SIZE_W-1:0]  remaining_reg;

    logic                        capture;
    logic [CNT_W-1:0]            count_sat;
    logic [SIZE_BITS-1:0]        rd_data;
    logic                        fits;
    logic [SIZE_BITS-1:0]        left;
    logic                        better;
    logic [SIZE_BITS-1:0]        cap_load;
    logic                        in_range;
    logic [31:0]                 bidx_ext;
    logic                        is_load;
    logic                        ram_we;
    logic [IDX_W-1:0]            ram_waddr;
    logic [SIZE_BITS-1:0]        ram_wdata;

    assign capture = cmd.take_item && req.valid;
    assign req.ready = cmd.take_item;
    assign cfg.ready = 1'b1;

    // Block count saturates at the table size
    assign count_sat = (32'(block_count_reg) > 32'(bfa_pkg::NUM_BLOCKS))
                       ? CNT_W'(bfa_pkg::NUM_BLOCKS) : CNT_W'(block_count_reg);

    // Compare of the registered table read
    assign fits   = 32'(rd_data) >= 32'(size_reg);
    assign left   = SIZE_BITS'(32'(rd_data) - 32'(size_reg));
    assign better = rd_pend_reg && fits && (!found_reg || (left < best_left_reg));

    // Load decode
    assign is_load  = (command_reg == bfa_pkg::CMD_LOAD);
    assign cap_load = SIZE_BITS'(32'(size_reg));
    assign bidx_ext = 32'(bidx_reg);
    assign in_range = bidx_ext < 32'(bfa_pkg::NUM_BLOCKS);

    // Table write on finish
    assign ram_we    = cmd.finish && (is_load ? in_range : found_reg);
    assign ram_waddr = is_load ? bidx_ext[IDX_W-1:0] : best_reg;
    assign ram_wdata = is_load ? cap_load : best_left_reg;

    bfa_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (bfa_pkg::NUM_BLOCKS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (scan_idx_reg[IDX_W-1:0]),
        .rdata (rd_data)
    );

    // Status to controller
    assign sts.req_valid  = req.valid;
    assign sts.req_load   = (req.command == bfa_pkg::CMD_LOAD);
    assign sts.count_zero = (block_count_reg == '0);
    assign sts.scan_last  = (scan_idx_reg == CNT_W'(32'(count_reg) - 32'd1));
    assign sts.out_free   = !out_valid_reg || rsp.ready;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_count_reg <= '0;
        end
        else if (cfg.valid)
        begin
            block_count_reg <= cfg.block_count;
        end
    end

    // Item capture
    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            command_reg <= req.command;
            bidx_reg    <= req.block_index;
            size_reg    <= req.size;
            count_reg   <= count_sat;
        end
    end

    // Scan control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg <= '0;
            rd_pend_reg  <= 1'b0;
            found_reg    <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= cmd.scan_step;
            if (capture)
            begin
                scan_idx_reg <= '0;
                found_reg    <= 1'b0;
            end
            else
            begin
                if (cmd.scan_step)
                begin
                    scan_idx_reg <= CNT_W'(32'(scan_idx_reg) + 32'd1);
                end
                if (better)
                begin
                    found_reg <= 1'b1;
                end
            end
        end
    end

    // Best candidate so far
    always_ff @(posedge clk)
    begin
        if (cmd.scan_step)
        begin
            rd_idx_reg <= scan_idx_reg[IDX_W-1:0];
        end
        if (better)
        begin
            best_reg      <= rd_idx_reg;
            best_left_reg <= left;
        end
    end

    // Result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            if (is_load)
            begin
                chosen_reg <= '0;
                if (in_range)
                begin
                    status_reg    <= bfa_pkg::STS_LOADED;
                    remaining_reg <= bfa_pkg::SIZE_W'(32'(cap_load));
                end
                else
                begin
                    status_reg    <= bfa_pkg::STS_BAD_INDEX;
                    remaining_reg <= '0;
                end
            end
            else if (found_reg)
            begin
                status_reg    <= bfa_pkg::STS_ALLOC;
                chosen_reg    <= bfa_pkg::BIDX_W'(32'(best_reg));
                remaining_reg <= bfa_pkg::SIZE_W'(32'(best_left_reg));
            end
            else
            begin
                status_reg    <= bfa_pkg::STS_NO_ALLOC;
                chosen_reg    <= '0;
                remaining_reg <= '0;
            end
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = status_reg;
    assign rsp.chosen_block = chosen_reg;
    assign rsp.remaining    = remaining_reg;

    // A compare only follows a read issued the cycle before
    a_rd_after_step: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> $past(cmd.scan_step))
        else $error("table compare without a preceding read");

    // Scan never reads beyond the saturated count
    a_scan_in_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_step |-> (scan_idx_reg < count_reg))
        else $error("scan index beyond block count");

    // A chosen block lies inside the searched range
    a_best_in_count: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg |-> (32'(best_reg) < 32'(count_reg)))
        else $error("best block outside searched range");

    // Finish never overwrites a result that was not taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid_reg || rsp.ready))
        else $error("result register overwritten");

endmodule

/* rtl/core/best_fit_block_allocator.sv */
// Load item: accepted in IDLE; FIN loads the result register once it is free, then IDLE again.
// Request item: SCAN reads count blocks (count = block_count saturated at NUM_BLOCKS), one table
//   read per cycle through the registered RAM port, DRAIN compares the last read, FIN loads the
//   result once free, then IDLE; a count of zero goes straight to FIN and answers no allocation.
// A finished result waits in its register while the next item is taken in.
// rst_n (async, active low) clears control and block_count; table stays undefined until loaded.
module best_fit_block_allocator (
    input  logic      clk,
    input  logic      rst_n,
    bfa_req_if.sink   req,
    bfa_rsp_if.source rsp,
    bfa_cfg_if.sink   cfg
);

    bfa_pkg::ctl_cmd_t cmd;
    bfa_pkg::ctl_sts_t sts;

    // Sequencer
    bfa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    // Table, scan and result register
    bfa_dpath u_dpath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg),
        .cmd   (cmd),
        .sts   (sts)
    );

endmodule
